// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the core RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/losgs_pkg.sv =====
// Package: constants, types and fixed-point helpers for the line-of-sight stabilizer.
package losgs_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam int TAB_LEN = 24;
  localparam int ITERS = (CORDIC_ITERS < TAB_LEN) ? CORDIC_ITERS : TAB_LEN;

  localparam int DEG_W = 18;
  localparam int AW = 34;
  localparam int TW = 33;
  localparam int VW = 35;
  localparam int MW = 34;

  localparam int TRIG_LAT = ITERS + 6;
  localparam int VEC_LAT = ITERS + 1;
  localparam int LAT = TRIG_LAT + 8 + 2 * VEC_LAT;

  localparam logic signed [AW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic signed [MW-1:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [2*MW-1:0] RND30 = 68'sd536870912;
  localparam logic signed [2*MW+1:0] RND30_SUM = 70'sd536870912;

  localparam logic signed [19:0] AZ_LIM = 20'sd205887;
  localparam logic signed [19:0] EL_LIM = 20'sd102944;

  localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
    34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
    34'sd1024, 34'sd512, 34'sd256, 34'sd128
  };

  typedef enum logic [2:0] {
    REG_REF_AZ    = 3'd0,
    REG_REF_EL    = 3'd1,
    REG_REF_ROLL  = 3'd2,
    REG_REF_PITCH = 3'd3,
    REG_REF_YAW   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [MW-1:0] cysp;
    logic signed [MW-1:0] sysp;
    logic signed [MW-1:0] sycr;
    logic signed [MW-1:0] sysr;
    logic signed [MW-1:0] cycr;
    logic signed [MW-1:0] cysr;
    logic signed [MW-1:0] sr;
    logic signed [MW-1:0] cr;
    logic signed [MW-1:0] m00;
    logic signed [MW-1:0] m10;
    logic signed [MW-1:0] m20;
    logic signed [MW-1:0] m21;
    logic signed [MW-1:0] m22;
  } dcm_part_t;

  function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                                input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = a * b;
    p = p + RND30;
    return p[MW+29:30];
  endfunction

  function automatic dcm_part_t dcm_part(input logic signed [MW-1:0] cr,
                                         input logic signed [MW-1:0] sr,
                                         input logic signed [MW-1:0] cp,
                                         input logic signed [MW-1:0] sp,
                                         input logic signed [MW-1:0] cy,
                                         input logic signed [MW-1:0] sy);
    dcm_part_t p;
    p.cysp = mulq(cy, sp);
    p.sysp = mulq(sy, sp);
    p.sycr = mulq(sy, cr);
    p.sysr = mulq(sy, sr);
    p.cycr = mulq(cy, cr);
    p.cysr = mulq(cy, sr);
    p.sr = sr;
    p.cr = cr;
    p.m00 = mulq(cy, cp);
    p.m10 = mulq(sy, cp);
    p.m20 = -sp;
    p.m21 = mulq(cp, sr);
    p.m22 = mulq(cp, cr);
    return p;
  endfunction

endpackage

// ===== rtl/core/losgs_trig.sv =====
// Pipelined sine/cosine of a Q8.8 degree angle by rotation CORDIC.
module losgs_trig import losgs_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [DEG_W-1:0] deg,
  output logic signed [TW-1:0]    cos_o,
  output logic signed [TW-1:0]    sin_o
);

  logic signed [19:0] t;
  logic signed [19:0] a_w;
  logic signed [16:0] a1;
  logic signed [16:0] af;
  logic               flip_w;
  logic [14:0]        mag2;
  logic               neg2, flip2;
  logic [30:0]        phi3;
  logic [28:0]        plo3;
  logic               neg3, flip3;
  logic [38:0]        qprod;
  logic [13:0]        qs4;
  logic [30:0]        phi4;
  logic               neg4, flip4;
  logic [AW-1:0]      zu;

  logic signed [TW-1:0] cx [ITERS+1];
  logic signed [TW-1:0] cy [ITERS+1];
  logic signed [AW-1:0] cz [ITERS+1];
  logic                 cf [ITERS+1];

  // wrap to [-180, 180)
  assign t = 20'(deg) + 20'sd230400;
  always_comb begin
    if (t >= 20'sd276480) begin
      a_w = t - 20'sd322560;
    end else if (t >= 20'sd184320) begin
      a_w = t - 20'sd230400;
    end else begin
      a_w = t - 20'sd138240;
    end
  end

  // fold into [-90, 90]
  always_comb begin
    flip_w = 1'b0;
    af = a1;
    if (a1 > 17'sd23040) begin
      af = a1 - 17'sd46080;
      flip_w = 1'b1;
    end else if (a1 < -17'sd23040) begin
      af = a1 + 17'sd46080;
      flip_w = 1'b1;
    end
  end

  // deg to Q30 rad: mag*pi*2^30/46080 = mag * 73204 + (mag * 19106 + 23040) / 46080
  assign qprod = {20'd0, plo3[28:10]} * 39'd745655;
  assign zu = {3'b000, phi4} + {20'd0, qs4};

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a_w[16:0];
      mag2 <= af[16] ? 15'(-af) : af[14:0];
      neg2 <= af[16];
      flip2 <= flip_w;
      phi3 <= {16'd0, mag2} * 31'd73204;
      plo3 <= 29'(mag2) * 29'd19106 + 29'd23040;
      neg3 <= neg2;
      flip3 <= flip2;
      qs4 <= qprod[38:25];
      phi4 <= phi3;
      neg4 <= neg3;
      flip4 <= flip3;
      cx[0] <= TW'(CORDIC_K);
      cy[0] <= '0;
      cz[0] <= neg4 ? -$signed(zu) : $signed(zu);
      cf[0] <= flip4;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][AW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_TAB[i];
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_TAB[i];
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= cf[ITERS] ? -cx[ITERS] : cx[ITERS];
      sin_o <= cf[ITERS] ? -cy[ITERS] : cy[ITERS];
    end
  end

endmodule

// ===== rtl/core/losgs_vec.sv =====
// Pipelined vectoring CORDIC: angle and scaled length of (x, y).
module losgs_vec import losgs_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] xi,
  input  logic signed [VW-1:0] yi,
  output logic signed [VW-1:0] xo,
  output logic signed [AW-1:0] ang
);

  logic signed [VW-1:0] vx [ITERS+1];
  logic signed [VW-1:0] vy [ITERS+1];
  logic signed [AW-1:0] vz [ITERS+1];
  logic                 zf [ITERS+1];

  // quarter-turn pre-rotation for the left half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (xi == '0) && (yi == '0);
      if (xi[VW-1] && !yi[VW-1]) begin
        vx[0] <= yi;
        vy[0] <= -xi;
        vz[0] <= HALF_PI;
      end else if (xi[VW-1]) begin
        vx[0] <= -yi;
        vy[0] <= xi;
        vz[0] <= -HALF_PI;
      end else begin
        vx[0] <= xi;
        vy[0] <= yi;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy[i][VW-1]) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + ATAN_TAB[i];
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - ATAN_TAB[i];
        end
        zf[i+1] <= zf[i];
      end
    end
  end

  assign xo = zf[ITERS] ? '0 : vx[ITERS];
  assign ang = zf[ITERS] ? '0 : vz[ITERS];

endmodule

// ===== rtl/core/los_gimbal_stabilizer_top.sv =====
// Line-of-sight gimbal stabilizer: attitude in, gimbal azimuth/elevation commands out.
//
// Usage:
//   s_* channel carries the current platform attitude (roll, pitch, yaw, Q8.8 deg).
//   m_* channel returns one result per input: az_cmd (Q3.16 rad), el_cmd (Q2.16 rad).
//   cfg_* channel writes the reference look angles and reference attitude;
//   write only while no transfer is in flight. cfg_ready is always high.
// Throughput: one transfer per cycle while m_tready does not stall the output.
//   Pipeline: a trig CORDIC pipe, two matrix build stages, two D product stages,
//   two rotate stages, two vectoring CORDIC pipes, a length multiply and an
//   output register.
//   The reference matrix and look vector ride along with each transfer.
// Reset: clears the pipeline valid bits and the config registers to zero.
// Stall: when m_tready is low with a result waiting, the whole pipeline
//   holds and s_tready drops; nothing is lost or repeated.
module los_gimbal_stabilizer_top import losgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // roll[16:0], pitch[32:17], yaw[50:33], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // az_cmd[18:0], el_cmd[36:19], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [17:0] cfg_data
);

`include "assert_macros.svh"

  logic signed [17:0] ref_az;
  logic signed [15:0] ref_el;
  logic signed [16:0] ref_roll;
  logic signed [15:0] ref_pitch;
  logic signed [17:0] ref_yaw;

  logic en;
  logic [LAT-1:0] vld;

  assign cfg_ready = 1'b1;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_az <= '0;
      ref_el <= '0;
      ref_roll <= '0;
      ref_pitch <= '0;
      ref_yaw <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_REF_AZ:    ref_az <= cfg_data;
        REG_REF_EL:    ref_el <= cfg_data[15:0];
        REG_REF_ROLL:  ref_roll <= cfg_data[16:0];
        REG_REF_PITCH: ref_pitch <= cfg_data[15:0];
        REG_REF_YAW:   ref_yaw <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // trig: 0..2 current roll/pitch/yaw, 3..5 reference attitude, 6 ref az, 7 ref el
  logic signed [DEG_W-1:0] deg [8];
  logic signed [TW-1:0]    tc [8];
  logic signed [TW-1:0]    ts [8];

  assign deg[0] = 18'($signed(s_tdata[16:0]));
  assign deg[1] = 18'($signed(s_tdata[32:17]));
  assign deg[2] = $signed(s_tdata[50:33]);
  assign deg[3] = 18'(ref_roll);
  assign deg[4] = 18'(ref_pitch);
  assign deg[5] = ref_yaw;
  assign deg[6] = ref_az;
  assign deg[7] = 18'(ref_el);

  for (genvar g = 0; g < 8; g++) begin : g_trig
    losgs_trig u_trig (
      .clk  (clk),
      .en   (en),
      .deg  (deg[g]),
      .cos_o(tc[g]),
      .sin_o(ts[g])
    );
  end

  // rotation matrices; index 0 current, 1 reference
  dcm_part_t            part [2];
  logic signed [MW-1:0] mat [2][3][3];
  logic signed [MW-1:0] v1a, v1b, v1c;
  logic signed [MW-1:0] v [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 2; m++) begin
        part[m] <= dcm_part(MW'(tc[3*m]), MW'(ts[3*m]), MW'(tc[3*m+1]), MW'(ts[3*m+1]),
                            MW'(tc[3*m+2]), MW'(ts[3*m+2]));
      end
      v1a <= mulq(MW'(tc[7]), MW'(tc[6]));
      v1b <= mulq(MW'(tc[7]), MW'(ts[6]));
      v1c <= MW'(ts[7]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 2; m++) begin
        mat[m][0][0] <= part[m].m00;
        mat[m][0][1] <= mulq(part[m].cysp, part[m].sr) - part[m].sycr;
        mat[m][0][2] <= mulq(part[m].cysp, part[m].cr) + part[m].sysr;
        mat[m][1][0] <= part[m].m10;
        mat[m][1][1] <= mulq(part[m].sysp, part[m].sr) + part[m].cycr;
        mat[m][1][2] <= mulq(part[m].sysp, part[m].cr) - part[m].cysr;
        mat[m][2][0] <= part[m].m20;
        mat[m][2][1] <= part[m].m21;
        mat[m][2][2] <= part[m].m22;
      end
      v[0] <= v1a;
      v[1] <= v1b;
      v[2] <= v1c;
    end
  end

  // D = transpose(R_cur) * R_ref
  logic signed [2*MW-1:0] dp [3][3][3];
  logic signed [MW-1:0]   dm [3][3];
  logic signed [MW-1:0]   vd [3];
  logic signed [MW-1:0]   vdd [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            dp[i][j][k] <= mat[0][k][i] * mat[1][k][j];
          end
        end
        vd[i] <= v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [2*MW+1:0] acc;
          acc = (2*MW+2)'(dp[i][j][0]) + (2*MW+2)'(dp[i][j][1])
              + (2*MW+2)'(dp[i][j][2]) + RND30_SUM;
          dm[i][j] <= acc[MW+29:30];
        end
        vdd[i] <= vd[i];
      end
    end
  end

  // w = D * v
  logic signed [2*MW-1:0] wp [3][3];
  logic signed [MW-1:0]   w [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          wp[i][k] <= dm[i][k] * vdd[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [2*MW+1:0] acc;
        acc = (2*MW+2)'(wp[i][0]) + (2*MW+2)'(wp[i][1]) + (2*MW+2)'(wp[i][2]) + RND30_SUM;
        w[i] <= acc[MW+29:30];
      end
    end
  end

  // azimuth and horizontal length
  logic signed [VW-1:0] x1;
  logic signed [AW-1:0] ang1;
  logic signed [MW-1:0] r_len;
  logic signed [MW-1:0] w2d [VEC_LAT+1];
  logic signed [AW-1:0] azd [VEC_LAT+1];
  logic signed [AW-1:0] ang2;

  losgs_vec u_vec_az (
    .clk(clk),
    .en (en),
    .xi (VW'(w[0])),
    .yi (VW'(w[1])),
    .xo (x1),
    .ang(ang1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      r_len <= mulq(MW'(x1), CORDIC_K);
      w2d[0] <= w[2];
      azd[0] <= ang1;
      for (int j = 1; j <= VEC_LAT; j++) begin
        w2d[j] <= w2d[j-1];
        azd[j] <= azd[j-1];
      end
    end
  end

  losgs_vec u_vec_el (
    .clk(clk),
    .en (en),
    .xi (VW'(r_len)),
    .yi (VW'(w2d[VEC_LAT])),
    .xo (),
    .ang(ang2)
  );

  // radians Q30 to Q3.16 (az) and Q2.16 (el) with clamp
  logic signed [AW-1:0] az_r, el_r;
  logic signed [19:0]   az_q, el_q;
  logic signed [19:0]   az_c, el_c;
  logic signed [18:0]   az_cmd;
  logic signed [17:0]   el_cmd;

  assign az_r = azd[VEC_LAT] + AW'(8192);
  assign el_r = ang2 + AW'(8192);
  assign az_q = az_r[AW-1:14];
  assign el_q = el_r[AW-1:14];

  always_comb begin
    az_c = az_q;
    if (az_q > AZ_LIM) begin
      az_c = AZ_LIM;
    end else if (az_q < -AZ_LIM) begin
      az_c = -AZ_LIM;
    end
    el_c = el_q;
    if (el_q > EL_LIM) begin
      el_c = EL_LIM;
    end else if (el_q < -EL_LIM) begin
      el_c = -EL_LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_cmd <= az_c[18:0];
      el_cmd <= el_c[17:0];
    end
  end

  assign m_tdata = {3'b000, el_cmd, az_cmd};

  `ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_tvalid)
  `ASSERT_RST(a_stall_freezes_pipe, clk, rst, !en |=> $stable(vld))
  `ASSERT_RST(a_az_in_range, clk, rst, m_tvalid |-> (az_cmd <= 19'sd205887) && (az_cmd >= -19'sd205887))
  `ASSERT_RST(a_el_in_range, clk, rst, m_tvalid |-> (el_cmd <= 18'sd102944) && (el_cmd >= -18'sd102944))

endmodule
